[hdl/rvd_pkg.sv]
// Shared types and constants for the RMS vector distance unit.
// No dependencies; compile first.
package rvd_pkg;

  localparam int ACC_W      = 46;  // Q30.16 sum of squared errors
  localparam int RMS_W      = 16;  // Q8.8 rms result
  localparam int TOTAL_W    = 13;  // element total as reported
  localparam int ROOT_W     = 23;  // magnitudes at or above 2^ROOT_W saturate the square
  localparam int SQ_REM_W   = ROOT_W + 2;
  localparam int DIV_STEPS  = ACC_W;
  localparam int SQRT_STEPS = ACC_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [RMS_W-1:0] RMS_MAX = {RMS_W{1'b1}};

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_DIV,
    ST_SQRT,
    ST_HOLD
  } rvd_state_t;

  typedef struct packed {
    logic take;
    logic div_step;
    logic sqrt_step;
    logic load;
  } rvd_cmd_t;

  typedef struct packed {
    logic last_taken;
    logic snap;
    logic out_free;
  } rvd_status_t;

endpackage

[hdl/rvd_interfaces.sv]
// Request and result channel interfaces of the RMS vector distance unit.
// Depends on rvd_pkg.
interface rvd_pair_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] first_value;
  logic signed [DATA_WIDTH-1:0] second_value;
  logic                         last_element;

  modport source (output valid, first_value, second_value, last_element, input ready);
  modport sink   (input valid, first_value, second_value, last_element, output ready);
endinterface

interface rvd_result_if;
  import rvd_pkg::*;
  logic               valid;
  logic               ready;
  logic [ACC_W-1:0]   sum_squared_error;
  logic [RMS_W-1:0]   rms_error;
  logic [TOTAL_W-1:0] element_total;
  logic               overflow;

  modport source (output valid, sum_squared_error, rms_error, element_total, overflow,
                  input ready);
  modport sink   (input valid, sum_squared_error, rms_error, element_total, overflow,
                  output ready);
endinterface

[hdl/rvd_controller.sv]
// Sequencer for the RMS vector distance unit: accumulate, drain, divide,
// square root, hand off. Depends on rvd_pkg.
module rvd_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  rvd_pkg::rvd_status_t status,
  output rvd_pkg::rvd_cmd_t    cmd
);
  import rvd_pkg::*;

  rvd_state_t        state, state_next;
  logic [STEP_W-1:0] step_count, step_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ACCUM;
      step_count <= '0;
    end else begin
      state      <= state_next;
      step_count <= step_count_next;
    end
  end

  always_comb begin
    state_next      = state;
    step_count_next = step_count;
    cmd             = '0;
    unique case (state)
      ST_ACCUM: begin
        cmd.take = 1'b1;
        if (status.last_taken) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (status.snap) begin
          state_next      = ST_DIV;
          step_count_next = STEP_W'(DIV_STEPS - 1);
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_count == '0) begin
          state_next      = ST_SQRT;
          step_count_next = STEP_W'(SQRT_STEPS - 1);
        end else begin
          step_count_next = step_count - 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_count == '0) state_next = ST_HOLD;
        else step_count_next = step_count - 1'b1;
      end
      ST_HOLD: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  // the end-of-vector snapshot only lands while draining
  a_snap_in_flush: assert property (@(posedge clk) disable iff (rst)
    status.snap |-> state == ST_FLUSH)
    else $error("snapshot outside flush");

  a_no_take_after_last: assert property (@(posedge clk) disable iff (rst)
    status.last_taken |=> !cmd.take)
    else $error("request taken while vector end pending");
endmodule

[hdl/rvd_datapath.sv]
// Datapath of the RMS vector distance unit: square-and-accumulate pipeline,
// bit-serial divider, two-bit-per-step square root, result register. Depends on rvd_pkg.
module rvd_datapath #(
  parameter int MAX_LEN    = 4096,
  parameter int DATA_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rvd_pkg::rvd_cmd_t             cmd,
  output rvd_pkg::rvd_status_t          status,
  input  logic                          in_valid,
  input  logic signed [DATA_WIDTH-1:0]  first_value,
  input  logic signed [DATA_WIDTH-1:0]  second_value,
  input  logic                          last_element,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rvd_pkg::ACC_W-1:0]     out_sum,
  output logic [rvd_pkg::RMS_W-1:0]     out_rms,
  output logic [rvd_pkg::TOTAL_W-1:0]   out_total,
  output logic                          out_overflow
);
  import rvd_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int DIFF_W = DATA_WIDTH + 1;
  localparam int EXT_W  = (DIFF_W > ROOT_W + 1) ? DIFF_W : ROOT_W + 1;
  localparam int TEXT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_LEN);
  localparam logic [EXT_W-1:0]  MAG_LIM  = EXT_W'(1) << ROOT_W;
  localparam logic [TEXT_W-1:0] MAX_TEXT = TEXT_W'(MAX_LEN);

  logic accept;
  assign accept = in_valid & cmd.take;

  // square-and-accumulate pipeline
  logic signed [DIFF_W-1:0] diff;
  logic                     diff_valid, diff_last;
  logic [DIFF_W-1:0]        mag;
  logic                     mag_valid, mag_last;
  logic [ACC_W-1:0]         square;
  logic                     sq_valid, sq_last;

  logic [EXT_W-1:0]  mag_ext;
  logic [ROOT_W-1:0] mag_low;
  logic [ACC_W-1:0]  product;

  assign mag_ext = EXT_W'(mag);
  assign mag_low = mag_ext[ROOT_W-1:0];
  assign product = ACC_W'(mag_low) * ACC_W'(mag_low);

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      mag_valid  <= 1'b0;
      sq_valid   <= 1'b0;
    end else begin
      diff_valid <= accept;
      mag_valid  <= diff_valid;
      sq_valid   <= mag_valid;
    end
    diff      <= DIFF_W'(first_value) - DIFF_W'(second_value);
    diff_last <= last_element & accept;
    mag       <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    mag_last  <= diff_last;
    square    <= (mag_ext >= MAG_LIM) ? ACC_MAX : product;
    sq_last   <= mag_last;
  end

  // accumulator, counter, overflow flag
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] count;
  logic             ovf;

  logic [ACC_W:0]      sum_wide;
  logic [ACC_W-1:0]    acc_next;
  logic [CNT_W-1:0]    count_next;
  logic                ovf_next;
  logic [TEXT_W-1:0]   count_text;
  logic                snap;

  assign sum_wide   = {1'b0, acc} + {1'b0, square};
  assign acc_next   = sum_wide[ACC_W] ? ACC_MAX : sum_wide[ACC_W-1:0];
  assign count_next = (count >= CNT_MAX) ? count : count + 1'b1;
  assign ovf_next   = ovf | (count >= CNT_MAX);
  assign count_text = TEXT_W'(count_next);
  assign snap       = sq_valid & sq_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (sq_valid) begin
      if (sq_last) begin
        acc   <= '0;
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        acc   <= acc_next;
        count <= count_next;
        ovf   <= ovf_next;
      end
    end
  end

  // snapshot, divider and square root share the work register
  logic [ACC_W-1:0]    work;
  logic [ACC_W-1:0]    snap_sum;
  logic [CNT_W-1:0]    divisor;
  logic [CNT_W-1:0]    rem;
  logic [TOTAL_W-1:0]  snap_total;
  logic                snap_ovf;
  logic [SQ_REM_W-1:0] sq_rem;
  logic [ROOT_W-1:0]   root;

  logic [CNT_W:0]      div_shift, div_sub;
  logic [SQ_REM_W+1:0] sq_shift, sq_trial, sq_sub;
  logic [RMS_W-1:0]    rms_sat;

  assign div_shift = {rem, work[ACC_W-1]};
  assign div_sub   = div_shift - {1'b0, divisor};
  assign sq_shift  = {sq_rem, work[ACC_W-1:ACC_W-2]};
  assign sq_trial  = (SQ_REM_W + 2)'({root, 2'b01});
  assign sq_sub    = sq_shift - sq_trial;
  assign rms_sat   = (root > ROOT_W'(RMS_MAX)) ? RMS_MAX : root[RMS_W-1:0];

  always_ff @(posedge clk) begin
    if (snap) begin
      work       <= acc_next;
      snap_sum   <= acc_next;
      divisor    <= count_next;
      snap_total <= count_text[TOTAL_W-1:0];
      snap_ovf   <= ovf_next;
      rem        <= '0;
      sq_rem     <= '0;
      root       <= '0;
    end else if (cmd.div_step) begin
      if (div_shift >= {1'b0, divisor}) begin
        rem  <= div_sub[CNT_W-1:0];
        work <= {work[ACC_W-2:0], 1'b1};
      end else begin
        rem  <= div_shift[CNT_W-1:0];
        work <= {work[ACC_W-2:0], 1'b0};
      end
    end else if (cmd.sqrt_step) begin
      work <= {work[ACC_W-3:0], 2'b00};
      if (sq_shift >= sq_trial) begin
        sq_rem <= sq_sub[SQ_REM_W-1:0];
        root   <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem <= sq_shift[SQ_REM_W-1:0];
        root   <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load) begin
      out_sum      <= snap_sum;
      out_rms      <= rms_sat;
      out_total    <= snap_total;
      out_overflow <= snap_ovf;
    end
  end

  always_comb begin
    status.last_taken = accept & last_element;
    status.snap       = snap;
    status.out_free   = ~out_valid | out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("element counter beyond maximum length");

  a_acc_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (sq_valid && !sq_last) |=> acc >= $past(acc))
    else $error("accumulator wrapped");

  a_ovf_total: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_overflow) |-> out_total == MAX_TEXT[TOTAL_W-1:0])
    else $error("overflow reported with short count");
endmodule

[hdl/rms_vector_distance_unit.sv]
// Top level of the RMS vector distance unit.
// Depends on rvd_pkg, rvd_interfaces, rvd_controller, rvd_datapath.
//
// Element pairs (signed Q8.8) are taken one per cycle while a vector is in
// progress; each adds its squared difference to a saturating Q30.16 sum.
// The pair flagged last closes the vector: the request port then stays
// not-ready while the accumulate pipeline drains, a one-bit-per-cycle
// divider forms sum / count and a two-bit-per-cycle square root unit
// forms the Q8.8 rms. One result is then placed in the output register and
// the next vector may start while it waits to be taken; a second vector end
// waits for that register to free.
// Vectors longer than MAX_LEN pairs set the overflow bit.
module rms_vector_distance_unit #(
  parameter int MAX_LEN    = 4096,
  parameter int DATA_WIDTH = 16
) (
  input logic          clk,
  input logic          rst,
  rvd_pair_if.sink     pairs,
  rvd_result_if.source result
);
  import rvd_pkg::*;

  rvd_cmd_t    cmd;
  rvd_status_t status;

  assign pairs.ready = cmd.take;

  rvd_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rvd_datapath #(
    .MAX_LEN    (MAX_LEN),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_valid     (pairs.valid),
    .first_value  (pairs.first_value),
    .second_value (pairs.second_value),
    .last_element (pairs.last_element),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_sum      (result.sum_squared_error),
    .out_rms      (result.rms_error),
    .out_total    (result.element_total),
    .out_overflow (result.overflow)
  );
endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for rms_vector_distance_unit: directed table, random vectors,
// full-scale vectors, checked against table results and an in-bench RMS error predictor.
// Depends on rvd_pkg, rvd_interfaces and the unit's RTL.
module testbench;
  import rvd_pkg::*;

  localparam int PAIR_W      = 16;
  localparam int VECTOR_MAX  = 4096;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_WAIT  = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int SHOWN_MAX   = 10;
  localparam int TABLE_ROWS  = 20;

  localparam longint unsigned SQUARE_CAP_MAG = 64'd1 << 23;
  localparam longint unsigned SSE_CAP        = (64'd1 << ACC_W) - 64'd1;
  localparam longint unsigned RMS_CAP        = 64'd65535;

  typedef enum {FILL_RANDOM, FILL_MAX_SPREAD} fill_kind_t;

  typedef struct packed {
    logic [ACC_W-1:0]   sum_squared_error;
    logic [RMS_W-1:0]   rms_error;
    logic [TOTAL_W-1:0] element_total;
    logic               overflow;
  } rms_result_t;

  typedef struct packed {
    logic signed [PAIR_W-1:0] first_value;
    logic signed [PAIR_W-1:0] second_value;
    logic                     last_element;
    logic                     fixed_want;
    rms_result_t              want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [TABLE_ROWS] = '{
    '{16'sh0000, 16'sh0000, 1'b1, 1'b1, '{46'd0, 16'd0, 13'd1, 1'b0}},
    '{16'sh7FFF, 16'sh8000, 1'b1, 1'b1, '{46'd4294836225, 16'd65535, 13'd1, 1'b0}},
    '{16'sh8000, 16'sh7FFF, 1'b1, 1'b1, '{46'd4294836225, 16'd65535, 13'd1, 1'b0}},
    '{16'sh8000, 16'sh8000, 1'b1, 1'b1, '{46'd0, 16'd0, 13'd1, 1'b0}},
    '{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, '{46'd0, 16'd0, 13'd1, 1'b0}},
    '{16'sh0100, 16'sh0000, 1'b1, 1'b1, '{46'd65536, 16'd256, 13'd1, 1'b0}},
    '{16'sh0000, 16'sh0100, 1'b1, 1'b1, '{46'd65536, 16'd256, 13'd1, 1'b0}},
    '{16'shFFFF, 16'sh0000, 1'b1, 1'b1, '{46'd1, 16'd1, 13'd1, 1'b0}},
    '{16'sh0001, 16'sh0000, 1'b0, 1'b0, '0},
    '{16'sh0000, 16'sh0001, 1'b0, 1'b0, '0},
    '{16'sh0002, 16'sh0000, 1'b1, 1'b1, '{46'd6, 16'd1, 13'd3, 1'b0}},
    '{16'sh5555, 16'shAAAA, 1'b0, 1'b0, '0},
    '{16'shAAAA, 16'sh5555, 1'b0, 1'b0, '0},
    '{16'sh7FFF, 16'sh0000, 1'b0, 1'b0, '0},
    '{16'sh8000, 16'sh0000, 1'b1, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 1'b0, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 1'b0, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b1, '{46'd0, 16'd0, 13'd3, 1'b0}},
    '{16'sh0C00, 16'shF400, 1'b0, 1'b0, '0},
    '{16'sh0001, 16'shFFFF, 1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  bit   gaps_on     = 1'b1;
  bit   pressure_on = 1'b0;
  bit   hold_done   = 1'b0;
  int   failures       = 0;
  int   results_seen   = 0;
  int   pairs_accepted = 0;
  int   random_pairs   = 0;
  int   cycle_count    = 0;

  // predictor state
  longint unsigned sse_acc       = 0;
  int unsigned     pair_count    = 0;
  bit              length_exceed = 1'b0;
  rms_result_t     vector_results_due[$];

  rvd_pair_if #(.DATA_WIDTH(PAIR_W)) pair_ch ();
  rvd_result_if res_ch ();

  rms_vector_distance_unit #(
    .MAX_LEN   (VECTOR_MAX),
    .DATA_WIDTH(PAIR_W)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .pairs (pair_ch),
    .result(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 23; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic bit predict_vector_error(input logic signed [PAIR_W-1:0] a, b,
                                              input logic lst, output rms_result_t res);
    longint          diff;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned mean;
    longint unsigned root;
    res  = '0;
    diff = longint'(a) - longint'(b);
    mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
    sq   = (mag >= SQUARE_CAP_MAG) ? SSE_CAP : mag * mag;
    if (sq > SSE_CAP - sse_acc) sse_acc = SSE_CAP;
    else sse_acc = sse_acc + sq;
    if (pair_count >= VECTOR_MAX) length_exceed = 1'b1;
    else pair_count++;
    if (!lst) return 1'b0;
    mean = (pair_count != 0) ? sse_acc / pair_count : 0;
    root = floor_root(mean);
    if (root > RMS_CAP) root = RMS_CAP;
    res.sum_squared_error = sse_acc[ACC_W-1:0];
    res.rms_error         = root[RMS_W-1:0];
    res.element_total     = pair_count[TOTAL_W-1:0];
    res.overflow          = length_exceed;
    sse_acc       = 0;
    pair_count    = 0;
    length_exceed = 1'b0;
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= SHOWN_MAX) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  function automatic logic signed [PAIR_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return PAIR_W'($urandom_range(0, 511)) - 16'sd256;
      default: return PAIR_W'($urandom);
    endcase
  endfunction

  // request side: called and returns at a falling edge
  task automatic send_pair(input logic signed [PAIR_W-1:0] a, b, input logic lst,
                           input logic fixed_want, input rms_result_t want);
    rms_result_t got;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      pair_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    pair_ch.valid        <= 1'b1;
    pair_ch.first_value  <= a;
    pair_ch.second_value <= b;
    pair_ch.last_element <= lst;
    do @(posedge clk); while (!pair_ch.ready);
    pairs_accepted++;
    if (predict_vector_error(a, b, lst, got))
      vector_results_due.push_back(fixed_want ? want : got);
    @(negedge clk);
  endtask

  task automatic send_vector(input int len, input fill_kind_t fill);
    logic signed [PAIR_W-1:0] a;
    logic signed [PAIR_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      if (fill == FILL_MAX_SPREAD) begin
        a = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        b = ~a;
      end else begin
        a = pick_sample();
        b = ($urandom_range(0, 2) == 0) ? pick_sample()
                                        : a + PAIR_W'($urandom_range(0, 1023)) - 16'sd512;
      end
      send_pair(a, b, i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic run_random(input int upto);
    int len;
    while (random_pairs < upto) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_vector(len, FILL_RANDOM);
      random_pairs += len;
    end
  endtask

  task automatic drain_vectors();
    pair_ch.valid <= 1'b0;
    while (vector_results_due.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin : result_sink
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_on && !hold_done) begin
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rms_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (vector_results_due.size() == 0) begin
        note_failure($sformatf("unexpected result sse=%0d rms=%0d total=%0d ovf=%0b",
                               res_ch.sum_squared_error, res_ch.rms_error,
                               res_ch.element_total, res_ch.overflow));
      end else begin
        want = vector_results_due.pop_front();
        if (want.sum_squared_error !== res_ch.sum_squared_error ||
            want.rms_error !== res_ch.rms_error ||
            want.element_total !== res_ch.element_total ||
            want.overflow !== res_ch.overflow) begin
          note_failure($sformatf(
            "expected sse=%0d rms=%0d total=%0d ovf=%0b, got sse=%0d rms=%0d total=%0d ovf=%0b",
            want.sum_squared_error, want.rms_error, want.element_total, want.overflow,
            res_ch.sum_squared_error, res_ch.rms_error, res_ch.element_total,
            res_ch.overflow));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", vector_results_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    rst                  = 1'b1;
    pair_ch.valid        = 1'b0;
    pair_ch.first_value  = '0;
    pair_ch.second_value = '0;
    pair_ch.last_element = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < TABLE_ROWS; i++)
      send_pair(DIRECTED[i].first_value, DIRECTED[i].second_value, DIRECTED[i].last_element,
                DIRECTED[i].fixed_want, DIRECTED[i].want);
    drain_vectors();

    run_random(150);
    pressure_on = 1'b1;
    run_random(400);

    // full-scale differences drive the rms to the top of its range
    send_vector(40, FILL_MAX_SPREAD);

    gaps_on = 1'b0;
    run_random(550);
    drain_vectors();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (vector_results_due.size() != 0)
      note_failure($sformatf("%0d results never arrived", vector_results_due.size()));
    $display("Run covered %0d request pairs and %0d vector results checked,", pairs_accepted,
             results_seen);
    $display("including field extremes, a long output stall and full-scale vectors.");
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
